FILE: src/spq_pkg.sv
// Shared types and codes for the sorted priority queue.
// No dependencies; imported by every module of the block.
`default_nettype none

package spq_pkg;

  // Access codes carried on op_i
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  // Result status codes
  localparam logic [1:0] STATUS_DONE  = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic       load;        // capture the accepted beat
    logic       rd;          // read the entry under the scan index
    logic       shift;       // move the read entry one slot along
    logic       place;       // write the new entry into the hole
    logic       capture;     // take the head entry as the result
    logic       finish;      // end the access and emit the result
    logic [1:0] fin_status;  // status to report on finish
  } spq_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic is_remove;  // current access is a remove
    logic full;       // queue holds its capacity
    logic empty;      // queue holds nothing
    logic idx_zero;   // scan index is zero
    logic idx_one;    // scan index is one
    logic greater;    // read priority is strictly above the new one
    logic last;       // remove scan is at the last held entry
  } spq_stat_t;

endpackage

`default_nettype wire

FILE: src/spq_ctrl.sv
// Controller state machine for the sorted priority queue.
// Depends on spq_pkg; drives spq_dp through command and status structs.
`default_nettype none

module spq_ctrl
  import spq_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      start_i,
  input  wire spq_stat_t stat_i,
  output spq_cmd_t       cmd_o,
  output logic           busy_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CHECK = 3'd1;
  localparam logic [2:0] ST_READ  = 3'd2;
  localparam logic [2:0] ST_STEP  = 3'd3;
  localparam logic [2:0] ST_PLACE = 3'd4;

  logic [2:0] state_q, state_d;

  // Sequence one access: check, then read and step through the entries
  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (stat_i.is_remove) begin
          if (stat_i.empty) begin
            cmd_o.finish     = 1'b1;
            cmd_o.fin_status = STATUS_EMPTY;
            state_d          = ST_IDLE;
          end else begin
            state_d = ST_READ;
          end
        end else if (stat_i.full) begin
          cmd_o.finish     = 1'b1;
          cmd_o.fin_status = STATUS_FULL;
          state_d          = ST_IDLE;
        end else if (stat_i.idx_zero) begin
          cmd_o.place      = 1'b1;
          cmd_o.finish     = 1'b1;
          cmd_o.fin_status = STATUS_DONE;
          state_d          = ST_IDLE;
        end else begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = ST_STEP;
      end
      ST_STEP: begin
        if (stat_i.is_remove) begin
          // head goes to the result, the rest move one slot toward the head
          if (stat_i.idx_zero) begin
            cmd_o.capture = 1'b1;
          end else begin
            cmd_o.shift = 1'b1;
          end
          if (stat_i.last) begin
            cmd_o.finish     = 1'b1;
            cmd_o.fin_status = STATUS_DONE;
            state_d          = ST_IDLE;
          end else begin
            state_d = ST_READ;
          end
        end else if (stat_i.greater) begin
          // open the hole one slot further toward the head
          cmd_o.shift = 1'b1;
          state_d     = stat_i.idx_one ? ST_PLACE : ST_READ;
        end else begin
          cmd_o.place      = 1'b1;
          cmd_o.finish     = 1'b1;
          cmd_o.fin_status = STATUS_DONE;
          state_d          = ST_IDLE;
        end
      end
      ST_PLACE: begin
        cmd_o.place      = 1'b1;
        cmd_o.finish     = 1'b1;
        cmd_o.fin_status = STATUS_DONE;
        state_d          = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Hold the state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

`default_nettype wire

FILE: src/spq_dp.sv
// Datapath of the sorted priority queue: entry memory, count, scan index, result.
// Depends on spq_pkg; commanded by spq_ctrl.
`default_nettype none

module spq_dp
  import spq_pkg::*;
#(
  parameter int CAPACITY      = 16,
  parameter int ITEM_BITS     = 32,
  parameter int PRIORITY_BITS = 16,
  parameter int CNT_W         = $clog2(CAPACITY + 1)
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire spq_cmd_t                 cmd_i,
  output spq_stat_t                     stat_o,
  input  wire logic                     op_i,
  input  wire logic [ITEM_BITS-1:0]     item_value_i,
  input  wire logic [PRIORITY_BITS-1:0] priority_req_i,
  output logic [ITEM_BITS-1:0]          out_item_o,
  output logic [PRIORITY_BITS-1:0]      out_priority_o,
  output logic [1:0]                    status_o,
  output logic [CNT_W-1:0]              entry_count_o,
  output logic                          done_o
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int EW = PRIORITY_BITS + ITEM_BITS;

  logic [EW-1:0]            mem_q [CAPACITY];
  logic [EW-1:0]            rd_q;
  logic                     op_q;
  logic [ITEM_BITS-1:0]     item_q;
  logic [PRIORITY_BITS-1:0] prio_q;
  logic [CNT_W-1:0]         count_q;
  logic [CNT_W-1:0]         idx_q;
  logic [CNT_W-1:0]         idx_m1;
  logic [CNT_W-1:0]         idx_p1;
  logic [ITEM_BITS-1:0]     res_item_q;
  logic [PRIORITY_BITS-1:0] res_prio_q;
  logic [1:0]               status_q;
  logic                     done_q;
  logic                     is_remove;
  logic [AW-1:0]            raddr;
  logic [AW-1:0]            waddr;
  logic [EW-1:0]            wdata;
  logic                     we;

  assign is_remove = (op_q == OP_REMOVE);
  assign idx_m1    = idx_q - CNT_W'(1);
  assign idx_p1    = idx_q + CNT_W'(1);

  // Insert scans from the tail toward the head, remove from the head outward
  assign raddr = is_remove ? idx_q[AW-1:0] : idx_m1[AW-1:0];
  assign waddr = is_remove ? idx_m1[AW-1:0] : idx_q[AW-1:0];
  assign wdata = cmd_i.place ? {prio_q, item_q} : rd_q;
  assign we    = cmd_i.shift | cmd_i.place;

  // Entry memory: one write, one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (cmd_i.rd) begin
      rd_q <= mem_q[raddr];
    end
  end

  // Capture the beat and hold the result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q       <= op_i;
      item_q     <= item_value_i;
      prio_q     <= priority_req_i;
      res_item_q <= '0;
      res_prio_q <= '0;
    end else if (cmd_i.capture) begin
      res_prio_q <= rd_q[EW-1:ITEM_BITS];
      res_item_q <= rd_q[ITEM_BITS-1:0];
    end
    if (cmd_i.finish) begin
      status_q <= cmd_i.fin_status;
    end
  end

  // Count, scan index and result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      idx_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= cmd_i.finish;
      if (cmd_i.load) begin
        idx_q <= (op_i == OP_REMOVE) ? '0 : count_q;
      end else if (cmd_i.shift || cmd_i.capture) begin
        idx_q <= is_remove ? idx_p1 : idx_m1;
      end
      if (cmd_i.finish && (cmd_i.fin_status == STATUS_DONE)) begin
        count_q <= is_remove ? (count_q - CNT_W'(1)) : (count_q + CNT_W'(1));
      end
    end
  end

  // Report to the controller
  assign stat_o.is_remove = is_remove;
  assign stat_o.full      = (count_q == CNT_W'(CAPACITY));
  assign stat_o.empty     = (count_q == '0);
  assign stat_o.idx_zero  = (idx_q == '0);
  assign stat_o.idx_one   = (idx_q == CNT_W'(1));
  assign stat_o.greater   = (rd_q[EW-1:ITEM_BITS] > prio_q);
  assign stat_o.last      = (idx_p1 == count_q);

  assign out_item_o     = res_item_q;
  assign out_priority_o = res_prio_q;
  assign status_o       = status_q;
  assign entry_count_o  = count_q;
  assign done_o         = done_q;

endmodule

`default_nettype wire

FILE: src/sorted_priority_queue_unit.sv
// Top level of the sorted priority queue.
// Depends on spq_pkg, spq_ctrl and spq_dp.
//
// Usage: drive op_i (insert or remove), item_value_i and priority_req_i with
// start high; the beat is taken at the edge where start is high and busy low.
// busy stays high until the access is finished. One result beat follows each
// access: done_o is high for exactly one cycle while out_item_o,
// out_priority_o, status_o and entry_count_o carry the result; the receiver
// must take it then, as there is no way to hold it off.
// Entries sit in one memory in ascending priority order; each entry visited is
// read in the READ state, then compared and written back in the STEP state.
// An insert moves each entry of greater priority one slot toward the tail,
// scanning from the tail and stopping at a smaller-or-equal entry or at the
// head; a remove reads every held entry and moves all but the head toward it.
// An insert into an empty queue, an insert when full and a remove when empty
// finish straight from the check.
// A new beat may be accepted in the cycle done_o is high.
// Reset empties the queue at once; entry memory contents are left as they are.
`default_nettype none

module sorted_priority_queue_unit
  import spq_pkg::*;
#(
  parameter int CAPACITY      = 16,
  parameter int ITEM_BITS     = 32,
  parameter int PRIORITY_BITS = 16
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic                               op_i,
  input  wire logic [ITEM_BITS-1:0]               item_value_i,
  input  wire logic [PRIORITY_BITS-1:0]           priority_req_i,
  output logic                                    done_o,
  output logic [ITEM_BITS-1:0]                    out_item_o,
  output logic [PRIORITY_BITS-1:0]                out_priority_o,
  output logic [1:0]                              status_o,
  output logic [$clog2(CAPACITY+1)-1:0]           entry_count_o
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  spq_cmd_t  cmd;
  spq_stat_t stat;

  spq_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy_o (busy)
  );

  spq_dp #(
    .CAPACITY     (CAPACITY),
    .ITEM_BITS    (ITEM_BITS),
    .PRIORITY_BITS(PRIORITY_BITS),
    .CNT_W        (CNT_W)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .op_i          (op_i),
    .item_value_i  (item_value_i),
    .priority_req_i(priority_req_i),
    .out_item_o    (out_item_o),
    .out_priority_o(out_priority_o),
    .status_o      (status_o),
    .entry_count_o (entry_count_o),
    .done_o        (done_o)
  );

endmodule

`default_nettype wire

FILE: src/spq_checker.sv
// Port-level checks for the sorted priority queue, bound to the top level.
// Depends on spq_pkg and sorted_priority_queue_unit.
`default_nettype none

module spq_checker
  import spq_pkg::*;
#(
  parameter int CAPACITY      = 16,
  parameter int ITEM_BITS     = 32,
  parameter int PRIORITY_BITS = 16
) (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          start,
  input wire logic                          busy,
  input wire logic                          done_o,
  input wire logic [ITEM_BITS-1:0]          out_item_o,
  input wire logic [PRIORITY_BITS-1:0]      out_priority_o,
  input wire logic [1:0]                    status_o,
  input wire logic [$clog2(CAPACITY+1)-1:0] entry_count_o
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  // An accepted beat keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted beat did not raise busy");

  // A remove from an empty queue reports an empty count
  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == STATUS_EMPTY)) |-> (entry_count_o == '0))
    else $error("empty status with nonzero count");

  // A refused insert reports a full count
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == STATUS_FULL)) |-> (entry_count_o == CNT_W'(CAPACITY)))
    else $error("full status without full count");

  // Refused accesses carry a zero payload
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o != STATUS_DONE)) |-> ((out_item_o == '0) && (out_priority_o == '0)))
    else $error("refused access with nonzero payload");

  // The count never exceeds the capacity at a result beat
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (entry_count_o <= CNT_W'(CAPACITY)))
    else $error("entry count above capacity");

endmodule

bind sorted_priority_queue_unit spq_checker #(
  .CAPACITY     (CAPACITY),
  .ITEM_BITS    (ITEM_BITS),
  .PRIORITY_BITS(PRIORITY_BITS)
) u_spq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .done_o        (done_o),
  .out_item_o    (out_item_o),
  .out_priority_o(out_priority_o),
  .status_o      (status_o),
  .entry_count_o (entry_count_o)
);

`default_nettype wire

FILE: bench/tb_sorted_priority_queue_unit.sv
// Self-checking testbench for sorted_priority_queue_unit: directed and random accesses
// are checked against an in-bench sorted-list predictor, one result beat per access.
// Depends on spq_pkg and the RTL of the block; nothing else.
`default_nettype none

module tb_sorted_priority_queue_unit;
  import spq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUEUE_DEPTH = 16;
  localparam int ITEM_W      = 32;
  localparam int PRIO_W      = 16;
  localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int DRAIN_WAIT  = 4 + 2 * QUEUE_DEPTH + 8;

  typedef struct packed {
    logic [ITEM_W-1:0]  item;
    logic [PRIO_W-1:0]  prio;
    logic [1:0]         status;
    logic [COUNT_W-1:0] count;
  } access_result_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic                op_i = OP_INSERT;
  logic [ITEM_W-1:0]   item_value_i = '0;
  logic [PRIO_W-1:0]   priority_req_i = '0;
  logic                done_o;
  logic [ITEM_W-1:0]   out_item_o;
  logic [PRIO_W-1:0]   out_priority_o;
  logic [1:0]          status_o;
  logic [COUNT_W-1:0]  entry_count_o;

  // Predictor copy of the queue, kept in ascending priority order
  logic [ITEM_W-1:0]   shadow_items [QUEUE_DEPTH];
  logic [PRIO_W-1:0]   shadow_prios [QUEUE_DEPTH];
  int                  shadow_count = 0;

  access_result_t      pending_results [$];

  int n_failures  = 0;
  int n_inserts   = 0;
  int n_removes   = 0;
  int n_full_hits = 0;
  int n_empty_hits = 0;
  int n_checked   = 0;
  int gap_pct     = 24;

  sorted_priority_queue_unit #(
    .CAPACITY     (QUEUE_DEPTH),
    .ITEM_BITS    (ITEM_W),
    .PRIORITY_BITS(PRIO_W)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .op_i          (op_i),
    .item_value_i  (item_value_i),
    .priority_req_i(priority_req_i),
    .done_o        (done_o),
    .out_item_o    (out_item_o),
    .out_priority_o(out_priority_o),
    .status_o      (status_o),
    .entry_count_o (entry_count_o)
  );

  always #6 clk_i = ~clk_i;

  // Compute the result of one access and update the shadow queue
  function automatic access_result_t predict_access(input logic op,
                                                    input logic [ITEM_W-1:0] item,
                                                    input logic [PRIO_W-1:0] prio);
    access_result_t res;
    int slot;
    res = '0;
    if (op == OP_INSERT) begin
      if (shadow_count >= QUEUE_DEPTH) begin
        res.status = STATUS_FULL;
      end else begin
        // place before the first entry of strictly greater priority
        slot = shadow_count;
        for (int i = shadow_count - 1; i >= 0; i--) begin
          if (shadow_prios[i] > prio) slot = i;
        end
        for (int i = shadow_count; i > slot; i--) begin
          shadow_items[i] = shadow_items[i-1];
          shadow_prios[i] = shadow_prios[i-1];
        end
        shadow_items[slot] = item;
        shadow_prios[slot] = prio;
        shadow_count++;
        res.status = STATUS_DONE;
      end
    end else begin
      if (shadow_count == 0) begin
        res.status = STATUS_EMPTY;
      end else begin
        res.item = shadow_items[0];
        res.prio = shadow_prios[0];
        for (int i = 1; i < shadow_count; i++) begin
          shadow_items[i-1] = shadow_items[i];
          shadow_prios[i-1] = shadow_prios[i];
        end
        shadow_count--;
        res.status = STATUS_DONE;
      end
    end
    res.count = shadow_count[COUNT_W-1:0];
    return res;
  endfunction

  // Random priority: often a narrow band to force ties, plus extremes and the full range
  function automatic logic [PRIO_W-1:0] pick_prio();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2, 3, 4: return PRIO_W'($urandom_range(7));
      default: return PRIO_W'($urandom_range(65535));
    endcase
  endfunction

  function automatic logic [ITEM_W-1:0] pick_item();
    case ($urandom_range(15))
      0:       return '0;
      1:       return '1;
      default: return ITEM_W'($urandom);
    endcase
  endfunction

  function automatic logic pick_op(input int insert_pct);
    return ($urandom_range(99) < insert_pct) ? OP_INSERT : OP_REMOVE;
  endfunction

  // With probability gap_pct, drop start for a random stretch, scrambling the payload meanwhile
  task automatic idle_gap();
    if ($urandom_range(99) < gap_pct) begin
      start          <= 1'b0;
      op_i           <= 1'($urandom);
      item_value_i   <= ITEM_W'($urandom);
      priority_req_i <= PRIO_W'($urandom);
      repeat ($urandom_range(1, 40)) @(posedge clk_i);
    end
  endtask

  // Offer one beat, hold it until taken, then queue its expected result
  task automatic send_access(input logic op, input logic [ITEM_W-1:0] item,
                             input logic [PRIO_W-1:0] prio);
    idle_gap();
    start          <= 1'b1;
    op_i           <= op;
    item_value_i   <= item;
    priority_req_i <= prio;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    pending_results.push_back(predict_access(op, item, prio));
    if (op == OP_INSERT) begin
      n_inserts++;
      if (pending_results[$].status == STATUS_FULL) n_full_hits++;
    end else begin
      n_removes++;
      if (pending_results[$].status == STATUS_EMPTY) n_empty_hits++;
    end
  endtask

  task automatic test_remove_when_empty();
    send_access(OP_REMOVE, '0, '0);
    send_access(OP_REMOVE, '1, '1);
  endtask

  task automatic test_field_extremes();
    send_access(OP_INSERT, '0, '1);
    send_access(OP_INSERT, '1, '0);
    send_access(OP_INSERT, 32'hA5A5_5A5A, 16'h8000);
    repeat (3) send_access(OP_REMOVE, '0, '0);
  endtask

  task automatic test_equal_priority_order();
    // ties must leave in arrival order; then a new head and a new tail
    for (int i = 0; i < 4; i++) send_access(OP_INSERT, 32'h1000_0000 + i, 16'd5);
    send_access(OP_INSERT, 32'h2000_0003, 16'd3);
    send_access(OP_INSERT, 32'h3000_0009, 16'd9);
    repeat (7) send_access(OP_REMOVE, '0, '0);
  endtask

  task automatic test_fill_and_drain();
    // swing between full and empty so both edge statuses recur
    repeat (4) begin
      repeat (40) send_access(pick_op(85), pick_item(), pick_prio());
      repeat (40) send_access(pick_op(15), pick_item(), pick_prio());
    end
  endtask

  task automatic test_mixed_traffic();
    gap_pct = 0;
    repeat (200) send_access(pick_op(55), pick_item(), pick_prio());
    gap_pct = 24;
    repeat (330) send_access(pick_op(50), pick_item(), pick_prio());
  endtask

  // Compare each result beat with the oldest expectation
  always @(posedge clk_i) begin : check_results
    access_result_t want;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        $error("result beat with no access outstanding");
        n_failures++;
      end else begin
        want = pending_results.pop_front();
        n_checked++;
        if (out_item_o !== want.item) begin
          $error("out_item: expected %h, got %h", want.item, out_item_o);
          n_failures++;
        end
        if (out_priority_o !== want.prio) begin
          $error("out_priority: expected %h, got %h", want.prio, out_priority_o);
          n_failures++;
        end
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          n_failures++;
        end
        if (entry_count_o !== want.count) begin
          $error("entry_count: expected %0d, got %0d", want.count, entry_count_o);
          n_failures++;
        end
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_remove_when_empty();
    test_field_extremes();
    test_equal_priority_order();
    test_fill_and_drain();
    test_mixed_traffic();

    // release start, wait out the last access and watch for strays
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      $error("%0d expected results never arrived", pending_results.size());
      n_failures++;
    end

    $display("Covered %0d inserts (%0d while full) and %0d removes (%0d while empty);",
             n_inserts, n_full_hits, n_removes, n_empty_hits);
    $display("%0d result beats checked, %0d mismatches.", n_checked, n_failures);
    if (n_failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Hard stop in case the handshake hangs
  initial begin
    #20ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule

`default_nettype wire

FILE: sorted_priority_queue_unit.f
src/spq_pkg.sv
src/spq_ctrl.sv
src/spq_dp.sv
src/sorted_priority_queue_unit.sv
src/spq_checker.sv
bench/tb_sorted_priority_queue_unit.sv
